// ===== hdl/cilr_pkg.sv =====
// Package: shared types and constants for the line rasterizer.
`timescale 1ns / 1ps
package cilr_pkg;
    localparam int unsigned COORD_W = 6;
    localparam int unsigned COLOR_W = 32;
    localparam int unsigned FRAME_W = 7;

    localparam logic [0:0] REG_FRAME_WIDTH  = 1'b0;
    localparam logic [0:0] REG_FRAME_HEIGHT = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SETUP,
        ST_DIV,
        ST_RUN
    } t_state;

    typedef struct packed {
        logic load;   // latch the line command
        logic setup;  // compute step count and lane deltas
        logic div;    // one bit of the per-lane delta / n divide
        logic step;   // emit one pixel, advance accumulators
    } t_cmd;

    typedef struct packed {
        logic zero_len;  // line has no pixels
        logic done;      // current pixel is the last
        logic div_last;  // final divide bit this cycle
    } t_status;
endpackage

// ===== hdl/cilr_if.sv =====
// Interfaces: valid/ready channels for line commands, pixels and config.
`timescale 1ns / 1ps
interface cilr_line_if;
    logic       valid;
    logic       ready;
    logic [5:0] start_x;
    logic [5:0] start_y;
    logic [5:0] end_x;
    logic [5:0] end_y;
    logic [31:0] start_color;
    logic [31:0] end_color;
    modport source (output valid, start_x, start_y, end_x, end_y, start_color, end_color,
                    input ready);
    modport sink (input valid, start_x, start_y, end_x, end_y, start_color, end_color,
                  output ready);
endinterface

interface cilr_pixel_if;
    logic        valid;
    logic        ready;
    logic [5:0]  pixel_x;
    logic [5:0]  pixel_y;
    logic [31:0] pixel_color;
    logic        inside_res;
    logic        last;
    modport source (output valid, pixel_x, pixel_y, pixel_color, inside_res, last,
                    input ready);
    modport sink (input valid, pixel_x, pixel_y, pixel_color, inside_res, last,
                  output ready);
endinterface

interface cilr_cfg_if;
    logic       valid;
    logic       ready;
    logic [0:0] index;
    logic [6:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ===== hdl/color_interpolated_line_raster.sv =====
// Top level: DDA line rasterizer with per-channel color interpolation.
`timescale 1ns / 1ps
// Usage:
//   in_line  : one line command per transfer (two endpoints, two colors).
//   out_pixel: one transfer per pixel; last marks the final pixel.
//   cfg      : index 0 frame_width, index 1 frame_height (7-bit data).
// Sequence: a command is taken in idle, then a setup state and a serial
//   divide state (|delta| / n for each lane, one quotient bit a cycle),
//   then n pixels, one per cycle while the receiver is ready,
//   n = max(|dx|,|dy|) (up to 63). A zero-length line gives no pixel and
//   returns from setup straight to idle.
// Output is registered; a stalled receiver holds the pixel and freezes
//   stepping. Reset returns to idle and sets both frame registers to
//   FRAME_SIZE. Config writes land in any cycle, so change the frame
//   registers only while no line is in flight.
module color_interpolated_line_raster
    import cilr_pkg::*;
#(
    parameter int unsigned FRAME_SIZE = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    cilr_line_if.sink   in_line,
    cilr_pixel_if.source out_pixel,
    cilr_cfg_if.sink    cfg
);
    t_cmd    cmd;
    t_status status;
    logic [6:0] r_fw, r_fh;
    logic       r_ovalid;
    logic [5:0] px, py;
    logic [31:0] pcol;
    logic       plast;
    logic       out_free;

    assign cfg.ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fw <= 7'(FRAME_SIZE);
            r_fh <= 7'(FRAME_SIZE);
        end else if (cfg.valid) begin
            case (cfg.index)
                REG_FRAME_WIDTH:  r_fw <= cfg.data;
                REG_FRAME_HEIGHT: r_fh <= cfg.data;
                default: ;
            endcase
        end
    end

    assign out_free = !r_ovalid || out_pixel.ready;

    cilr_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_line.valid), .o_in_ready(in_line.ready),
        .i_out_free(out_free), .i_status(status), .o_cmd(cmd)
    );

    cilr_dp u_dp (
        .i_clk(i_clk), .i_cmd(cmd),
        .i_x0(in_line.start_x), .i_y0(in_line.start_y),
        .i_x1(in_line.end_x), .i_y1(in_line.end_y),
        .i_c0(in_line.start_color), .i_c1(in_line.end_color),
        .o_status(status), .o_px(px), .o_py(py), .o_color(pcol), .o_last(plast)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_ovalid <= 1'b0;
        else if (cmd.step) r_ovalid <= 1'b1;
        else if (out_pixel.ready) r_ovalid <= 1'b0;
        if (cmd.step) begin
            out_pixel.pixel_x <= px;
            out_pixel.pixel_y <= py;
            out_pixel.pixel_color <= pcol;
            out_pixel.inside_res <= ({1'b0, px} < r_fw) && ({1'b0, py} < r_fh);
            out_pixel.last <= plast;
        end
    end
    assign out_pixel.valid = r_ovalid;

`ifndef SYNTHESIS
    a_step_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.step |-> out_free) else $error("step while output full");
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.step |-> !in_line.ready) else $error("input ready while stepping");
    a_alpha: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid |-> out_pixel.pixel_color[7:0] == 8'hFF) else $error("alpha lost");
`endif
endmodule

// ===== hdl/cilr_ctrl.sv =====
// Controller: sequences load, setup, divide and per-pixel stepping.
`timescale 1ns / 1ps
module cilr_ctrl
    import cilr_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  logic    i_out_free,
    input  t_status i_status,
    output t_cmd    o_cmd
);
    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= ST_IDLE;
        else r_state <= n_state;
    end

    always_comb begin
        n_state = r_state;
        o_cmd = '0;
        o_in_ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state = ST_SETUP;
                end
            end
            ST_SETUP: begin
                o_cmd.setup = 1'b1;
                n_state = i_status.zero_len ? ST_IDLE : ST_DIV;
            end
            ST_DIV: begin
                o_cmd.div = 1'b1;
                if (i_status.div_last) n_state = ST_RUN;
            end
            ST_RUN: begin
                if (i_out_free) begin
                    o_cmd.step = 1'b1;
                    if (i_status.done) n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end
endmodule

// ===== hdl/cilr_dp.sv =====
// Datapath: endpoint ordering and exact incremental interpolation.
`timescale 1ns / 1ps
module cilr_dp
    import cilr_pkg::*;
(
    input  logic        i_clk,
    input  t_cmd        i_cmd,
    input  logic [5:0]  i_x0,
    input  logic [5:0]  i_y0,
    input  logic [5:0]  i_x1,
    input  logic [5:0]  i_y1,
    input  logic [31:0] i_c0,
    input  logic [31:0] i_c1,
    output t_status     o_status,
    output logic [5:0]  o_px,
    output logic [5:0]  o_py,
    output logic [31:0] o_color,
    output logic        o_last
);
    // Each lane tracks num = a*n + k*d as value*n + rem, rem in [0,n).
    // |d| = q*n + r is found once per line by an 8-bit restoring divide;
    // a step then adds or subtracts q and r with a single carry/borrow.
    logic [5:0]  r_x0, r_y0, r_x1, r_y1;
    logic [31:0] r_c0, r_c1;
    logic        r_xmaj;
    logic [5:0]  r_n, r_k;
    logic [5:0]  r_major;
    logic [2:0]  r_dcnt;
    // four lanes: minor coordinate, red, green, blue
    logic [7:0]  r_val [4];
    logic [5:0]  r_rem [4];
    logic [7:0]  r_d   [4];   // |delta|, shifted out while dividing
    logic        r_neg [4];
    logic [7:0]  r_q   [4];   // floor(|delta| / n)
    logic [5:0]  r_r   [4];   // |delta| mod n (partial remainder while dividing)

    logic [5:0] adx, ady, n_len;
    logic       xmaj, swp;
    logic [7:0] a_s [4];
    logic [7:0] b_s [4];
    logic [6:0] div_trial [4];
    logic       div_ge    [4];
    logic [6:0] div_diff  [4];
    logic [6:0] step_sum  [4];
    logic       carry     [4];
    logic [7:0] nxt_val   [4];
    logic [5:0] nxt_rem   [4];

    always_comb begin
        adx = (r_x0 > r_x1) ? r_x0 - r_x1 : r_x1 - r_x0;
        ady = (r_y0 > r_y1) ? r_y0 - r_y1 : r_y1 - r_y0;
        xmaj = (adx != 6'd0) && (ady <= adx);
        swp = xmaj ? (r_x0 > r_x1) : (r_y0 > r_y1);
        n_len = xmaj ? adx : ady;
        a_s[0] = {2'b0, xmaj ? (swp ? r_y1 : r_y0) : (swp ? r_x1 : r_x0)};
        b_s[0] = {2'b0, xmaj ? (swp ? r_y0 : r_y1) : (swp ? r_x0 : r_x1)};
        for (int i = 1; i < 4; i++) begin
            a_s[i] = swp ? r_c1[32-8*i +: 8] : r_c0[32-8*i +: 8];
            b_s[i] = swp ? r_c0[32-8*i +: 8] : r_c1[32-8*i +: 8];
        end
    end

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            // one restoring-divide bit
            div_trial[i] = {r_r[i], r_d[i][7]};
            div_ge[i] = div_trial[i] >= {1'b0, r_n};
            div_diff[i] = div_trial[i] - {1'b0, r_n};
            // one interpolation step
            if (r_neg[i]) begin
                carry[i] = r_rem[i] < r_r[i];
                step_sum[i] = {1'b0, r_rem[i]} - {1'b0, r_r[i]}
                              + (carry[i] ? {1'b0, r_n} : 7'd0);
                nxt_val[i] = r_val[i] - r_q[i] - {7'd0, carry[i]};
            end else begin
                step_sum[i] = {1'b0, r_rem[i]} + {1'b0, r_r[i]};
                carry[i] = step_sum[i] >= {1'b0, r_n};
                if (carry[i]) step_sum[i] = step_sum[i] - {1'b0, r_n};
                nxt_val[i] = r_val[i] + r_q[i] + {7'd0, carry[i]};
            end
            nxt_rem[i] = step_sum[i][5:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_x0 <= i_x0; r_y0 <= i_y0; r_x1 <= i_x1; r_y1 <= i_y1;
            r_c0 <= i_c0; r_c1 <= i_c1;
        end
        if (i_cmd.setup) begin
            r_xmaj <= xmaj;
            r_n <= n_len;
            r_k <= 6'd0;
            r_dcnt <= 3'd0;
            r_major <= xmaj ? (swp ? r_x1 : r_x0) : (swp ? r_y1 : r_y0);
            for (int i = 0; i < 4; i++) begin
                r_val[i] <= a_s[i];
                r_rem[i] <= 6'd0;
                r_neg[i] <= b_s[i] < a_s[i];
                r_d[i] <= (b_s[i] < a_s[i]) ? a_s[i] - b_s[i] : b_s[i] - a_s[i];
                r_q[i] <= 8'd0;
                r_r[i] <= 6'd0;
            end
        end else if (i_cmd.div) begin
            r_dcnt <= r_dcnt + 3'd1;
            for (int i = 0; i < 4; i++) begin
                r_d[i] <= {r_d[i][6:0], 1'b0};
                r_q[i] <= {r_q[i][6:0], div_ge[i]};
                r_r[i] <= div_ge[i] ? div_diff[i][5:0] : div_trial[i][5:0];
            end
        end else if (i_cmd.step) begin
            r_k <= r_k + 6'd1;
            r_major <= r_major + 6'd1;
            for (int i = 0; i < 4; i++) begin
                r_val[i] <= nxt_val[i];
                r_rem[i] <= nxt_rem[i];
            end
        end
    end

    assign o_status.zero_len = (n_len == 6'd0);
    assign o_status.done = (r_k + 6'd1 == r_n);
    assign o_status.div_last = (r_dcnt == 3'd7);
    assign o_px = r_xmaj ? r_major : r_val[0][5:0];
    assign o_py = r_xmaj ? r_val[0][5:0] : r_major;
    assign o_color = {r_val[1], r_val[2], r_val[3], 8'hFF};
    assign o_last = (r_k + 6'd1 == r_n);
endmodule
